[rtl/dpb_pkg.sv]
// ----------------------------------------------------------------------------
// dpb_pkg: shared types and constants for depth pixel back-projection
// Payload structs, the configuration register bank and its index codes.
// ----------------------------------------------------------------------------
package dpb_pkg;

    // Default elaboration limits
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int MAX_STRIDE_DEF = 64;

    // Fixed internal widths (cover the full parameter ranges)
    localparam int POS_CMP_W    = 15;  // holds 16384 for width/row compares
    localparam int STRIDE_CMP_W = 9;   // holds 256 for stride compares
    localparam int MAG_W        = 18;  // |16*pos - center| magnitude
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 24;

    // Queue depths
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 8;

    // Register index codes
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_STEP  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_DEPTH    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_DEPTH    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_INV_FOCAL_X  = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_INV_FOCAL_Y  = 3'd7;

    // Register reset values
    localparam logic [12:0] IMAGE_WIDTH_RST  = 13'd640;
    localparam logic [6:0]  SAMPLE_STEP_RST  = 7'd4;
    localparam logic [15:0] MIN_DEPTH_RST    = 16'd300;
    localparam logic [15:0] MAX_DEPTH_RST    = 16'd40000;
    localparam logic [15:0] CENTER_X_RST     = 16'd5120;
    localparam logic [15:0] CENTER_Y_RST     = 16'd3840;
    localparam logic [23:0] INV_FOCAL_X_RST  = 24'd33554;
    localparam logic [23:0] INV_FOCAL_Y_RST  = 24'd33554;

    typedef struct packed {
        logic [12:0] image_width;
        logic [6:0]  sample_step;
        logic [15:0] min_depth_mm;
        logic [15:0] max_depth_mm;
        logic [15:0] center_x_q4;
        logic [15:0] center_y_q4;
        logic [23:0] inv_focal_x;
        logic [23:0] inv_focal_y;
    } cfg_t;

    typedef struct packed {
        logic [15:0] depth_mm;
        logic        frame_start;
    } pixel_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [15:0]        point_z;
        logic [23:0]        point_index;
    } point_t;

    // Kept pixel handed from front to back: offsets as sign and magnitude
    typedef struct packed {
        logic             x_neg;
        logic [MAG_W-1:0] x_mag;
        logic             y_neg;
        logic [MAG_W-1:0] y_mag;
        logic [15:0]      depth_mm;
        logic [23:0]      index;
    } kept_t;

endpackage

[rtl/dpb_queue.sv]
// ----------------------------------------------------------------------------
// dpb_queue: small synchronous FIFO
// Register-based queue with push/full and pop/empty; head shown while not empty.
// ----------------------------------------------------------------------------
module dpb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/dpb_front.sv]
// ----------------------------------------------------------------------------
// dpb_front: raster tracking and pixel selection
// Tracks column/row and stride phases, filters depth, and forms kept items.
// ----------------------------------------------------------------------------
module dpb_front #(
    parameter int MAX_WIDTH  = dpb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dpb_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_STRIDE = dpb_pkg::MAX_STRIDE_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  dpb_pkg::cfg_t   cfg,
    input  logic            accept,
    input  dpb_pkg::pixel_t pixel,
    output logic            keep_push,
    output dpb_pkg::kept_t  keep_item
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PW = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1;
    localparam int PCW = dpb_pkg::POS_CMP_W;
    localparam int SCW = dpb_pkg::STRIDE_CMP_W;
    localparam int MW  = dpb_pkg::MAG_W;

    logic [CW-1:0] column_reg, column_next, cur_column;
    logic [RW-1:0] row_reg, row_next, cur_row;
    logic [PW-1:0] col_phase_reg, col_phase_next, cur_col_phase;
    logic [PW-1:0] row_phase_reg, row_phase_next, cur_row_phase;
    logic [23:0]   count_reg, count_next, cur_count;

    logic [SCW-1:0] stride_eff;
    logic [PCW-1:0] width_eff;
    logic           keep;
    logic [MW-1:0]  p16_x, p16_y;

    // effective stride and width
    always_comb
    begin
        if (cfg.sample_step == '0)
        begin
            stride_eff = SCW'(1);
        end
        else if (SCW'(cfg.sample_step) > SCW'(MAX_STRIDE))
        begin
            stride_eff = SCW'(MAX_STRIDE);
        end
        else
        begin
            stride_eff = SCW'(cfg.sample_step);
        end

        if (cfg.image_width == '0)
        begin
            width_eff = PCW'(1);
        end
        else if (PCW'(cfg.image_width) > PCW'(MAX_WIDTH))
        begin
            width_eff = PCW'(MAX_WIDTH);
        end
        else
        begin
            width_eff = PCW'(cfg.image_width);
        end
    end

    // frame start clears position before the pixel is used
    always_comb
    begin
        if (pixel.frame_start)
        begin
            cur_column    = '0;
            cur_row       = '0;
            cur_col_phase = '0;
            cur_row_phase = '0;
            cur_count     = '0;
        end
        else
        begin
            cur_column    = column_reg;
            cur_row       = row_reg;
            cur_col_phase = col_phase_reg;
            cur_row_phase = row_phase_reg;
            cur_count     = count_reg;
        end
    end

    // selection: on the stride grid and inside the depth window
    assign keep = (cur_col_phase == '0) && (cur_row_phase == '0)
               && (pixel.depth_mm != '0)
               && (pixel.depth_mm >= cfg.min_depth_mm)
               && (pixel.depth_mm <= cfg.max_depth_mm);

    assign keep_push = accept && keep;

    // offset from principal point as sign and magnitude
    assign p16_x = MW'({cur_column, 4'b0000});
    assign p16_y = MW'({cur_row, 4'b0000});

    always_comb
    begin
        keep_item.x_neg = MW'(cfg.center_x_q4) > MW'({cur_column, 4'b0000});
        keep_item.x_mag = keep_item.x_neg ? MW'(cfg.center_x_q4) - p16_x
                                          : p16_x - MW'(cfg.center_x_q4);
        keep_item.y_neg = MW'(cfg.center_y_q4) > MW'({cur_row, 4'b0000});
        keep_item.y_mag = keep_item.y_neg ? MW'(cfg.center_y_q4) - p16_y
                                          : p16_y - MW'(cfg.center_y_q4);
        keep_item.depth_mm = pixel.depth_mm;
        keep_item.index    = cur_count;
    end

    // raster advance
    always_comb
    begin
        column_next    = cur_column;
        row_next       = cur_row;
        col_phase_next = cur_col_phase;
        row_phase_next = cur_row_phase;
        count_next     = keep ? cur_count + 24'd1 : cur_count;
        if (PCW'(cur_column) + PCW'(1) >= width_eff)
        begin
            column_next    = '0;
            col_phase_next = '0;
            if (PCW'(cur_row) + PCW'(1) >= PCW'(MAX_HEIGHT))
            begin
                row_next       = '0;
                row_phase_next = '0;
            end
            else
            begin
                row_next       = cur_row + 1'b1;
                row_phase_next = (SCW'(cur_row_phase) + SCW'(1) >= stride_eff)
                               ? '0 : cur_row_phase + 1'b1;
            end
        end
        else
        begin
            column_next    = cur_column + 1'b1;
            col_phase_next = (SCW'(cur_col_phase) + SCW'(1) >= stride_eff)
                           ? '0 : cur_col_phase + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg    <= '0;
            row_reg       <= '0;
            col_phase_reg <= '0;
            row_phase_reg <= '0;
            count_reg     <= '0;
        end
        else if (accept)
        begin
            column_reg    <= column_next;
            row_reg       <= row_next;
            col_phase_reg <= col_phase_next;
            row_phase_reg <= row_phase_next;
            count_reg     <= count_next;
        end
    end

    // kept pixels carry consecutive indexes within a frame
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        keep_push && !pixel.frame_start |-> keep_item.index == count_reg)
        else $error("kept index does not match running count");

    a_first_index: assert property (@(posedge clk) disable iff (!rst_n)
        keep_push && pixel.frame_start |-> keep_item.index == '0)
        else $error("first kept pixel of frame has nonzero index");

    a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
        SCW'(col_phase_reg) < SCW'(MAX_STRIDE) || MAX_STRIDE == 1)
        else $error("column phase out of range");

endmodule

[rtl/dpb_back.sv]
// ----------------------------------------------------------------------------
// dpb_back: back-projection pipeline
// Multiplies offset by depth and reciprocal focal, rounds, saturates, queues.
// ----------------------------------------------------------------------------
module dpb_back (
    input  logic            clk,
    input  logic            rst_n,
    input  dpb_pkg::cfg_t   cfg,
    input  dpb_pkg::kept_t  item,
    input  logic            item_empty,
    output logic            item_pop,
    input  logic            pop,
    output logic            empty,
    output dpb_pkg::point_t point
);

    localparam int MW  = dpb_pkg::MAG_W;
    localparam int PRW = MW + 16;          // offset * depth
    localparam int HW  = PRW / 2;          // half of that product
    localparam int PPW = HW + 24;          // half * reciprocal
    localparam int SW  = PRW + 24 + 1;     // full sum with rounding headroom
    localparam int RW  = SW - 24;          // rounded magnitude
    localparam int OD  = dpb_pkg::OUT_DEPTH;
    localparam int OCW = $clog2(OD + 1);

    // slot reservation keeps the pipeline from ever overrunning the result queue
    logic [OCW-1:0] reserved_reg, reserved_next;
    logic           out_full, out_pop;

    // stage 1: offset * depth
    logic           s1_valid_reg;
    logic           s1_xneg_reg, s1_yneg_reg;
    logic [PRW-1:0] s1_px_reg, s1_py_reg;
    logic [15:0]    s1_z_reg;
    logic [23:0]    s1_idx_reg;

    // stage 2: split product * reciprocal
    logic           s2_valid_reg;
    logic           s2_xneg_reg, s2_yneg_reg;
    logic [PPW-1:0] s2_xlo_reg, s2_xhi_reg, s2_ylo_reg, s2_yhi_reg;
    logic [15:0]    s2_z_reg;
    logic [23:0]    s2_idx_reg;

    // stage 3: recombine and round
    logic           s3_valid_reg;
    logic           s3_xneg_reg, s3_yneg_reg;
    logic [RW-1:0]  s3_xmag_reg, s3_ymag_reg;
    logic [15:0]    s3_z_reg;
    logic [23:0]    s3_idx_reg;

    logic [SW-1:0]   sum_x, sum_y;
    dpb_pkg::point_t result;

    function automatic logic [31:0] saturate(input logic neg, input logic [RW-1:0] mag);
        logic [31:0] res;
        begin
            if (neg)
            begin
                if (mag > RW'(32'h8000_0000))
                begin
                    res = 32'h8000_0000;
                end
                else
                begin
                    res = 32'd0 - mag[31:0];
                end
            end
            else
            begin
                if (mag > RW'(32'h7FFF_FFFF))
                begin
                    res = 32'h7FFF_FFFF;
                end
                else
                begin
                    res = mag[31:0];
                end
            end
            return res;
        end
    endfunction

    assign item_pop = !item_empty && (reserved_reg < OCW'(OD));

    // reservation count: up on issue, down on result transfer
    always_comb
    begin
        reserved_next = reserved_reg;
        if (item_pop && !out_pop)
        begin
            reserved_next = reserved_reg + 1'b1;
        end
        else if (out_pop && !item_pop)
        begin
            reserved_next = reserved_reg - 1'b1;
        end
    end

    // round to nearest, ties away from zero (on magnitude)
    assign sum_x = SW'({s2_xhi_reg, {HW{1'b0}}}) + SW'(s2_xlo_reg) + SW'(1 << 23);
    assign sum_y = SW'({s2_yhi_reg, {HW{1'b0}}}) + SW'(s2_ylo_reg) + SW'(1 << 23);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserved_reg <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            reserved_reg <= reserved_next;
            s1_valid_reg <= item_pop;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        s1_xneg_reg <= item.x_neg;
        s1_yneg_reg <= item.y_neg;
        s1_px_reg   <= PRW'(item.x_mag) * PRW'(item.depth_mm);
        s1_py_reg   <= PRW'(item.y_mag) * PRW'(item.depth_mm);
        s1_z_reg    <= item.depth_mm;
        s1_idx_reg  <= item.index;

        s2_xneg_reg <= s1_xneg_reg;
        s2_yneg_reg <= s1_yneg_reg;
        s2_xlo_reg  <= PPW'(s1_px_reg[HW-1:0]) * PPW'(cfg.inv_focal_x);
        s2_xhi_reg  <= PPW'(s1_px_reg[PRW-1:HW]) * PPW'(cfg.inv_focal_x);
        s2_ylo_reg  <= PPW'(s1_py_reg[HW-1:0]) * PPW'(cfg.inv_focal_y);
        s2_yhi_reg  <= PPW'(s1_py_reg[PRW-1:HW]) * PPW'(cfg.inv_focal_y);
        s2_z_reg    <= s1_z_reg;
        s2_idx_reg  <= s1_idx_reg;

        s3_xneg_reg <= s2_xneg_reg;
        s3_yneg_reg <= s2_yneg_reg;
        s3_xmag_reg <= sum_x[SW-1:24];
        s3_ymag_reg <= sum_y[SW-1:24];
        s3_z_reg    <= s2_z_reg;
        s3_idx_reg  <= s2_idx_reg;
    end

    // saturation and sign, then into the result queue
    always_comb
    begin
        result.point_x     = saturate(s3_xneg_reg, s3_xmag_reg);
        result.point_y     = saturate(s3_yneg_reg, s3_ymag_reg);
        result.point_z     = s3_z_reg;
        result.point_index = s3_idx_reg;
    end

    assign out_pop = pop && !empty;

    dpb_queue #(
        .WIDTH ($bits(dpb_pkg::point_t)),
        .DEPTH (OD)
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (s3_valid_reg),
        .wr_data (result),
        .full    (out_full),
        .pop     (out_pop),
        .rd_data (point),
        .empty   (empty)
    );

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> !out_full)
        else $error("result queue written while full");

    a_reserve_bound: assert property (@(posedge clk) disable iff (!rst_n)
        reserved_reg <= OCW'(OD))
        else $error("reservation count above queue depth");

    a_issue_flows: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |=> s1_valid_reg ##1 s2_valid_reg ##1 s3_valid_reg)
        else $error("issued item lost in pipeline");

    a_empty_reserved: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> reserved_reg != '0)
        else $error("result waiting with no reservation");

endmodule

[rtl/depth_pixel_backprojection_top.sv]
// ----------------------------------------------------------------------------
// depth_pixel_backprojection_top: depth raster to point cloud
// Usage:
//   Pixels enter in raster order on push/full with payload "pixel"; a
//   transfer happens on a clock edge with push high and full low. Column,
//   row and stride phase are tracked internally; frame_start marks pixel
//   (0,0) and restarts the point index.
//   Points leave on empty/pop: the oldest point sits on "point" while empty
//   is low and is transferred on an edge with pop high.
//   Throughput: one pixel per clock while full is low. A kept pixel passes
//   the 4-entry queue, two multiplier stages, the round stage and the
//   result queue write before its point shows. Rejected pixels produce nothing.
//   A 4-entry queue parts the selection front from the multiplier pipeline,
//   and an 8-entry result queue sits at the output; when pop is held low the
//   pipeline stops issuing once results fill that queue, then full rises.
//   Configuration uses cfg_valid/cfg_ready with cfg_index and cfg_data;
//   cfg_ready is always high. Write only while the block is idle.
//   Reset (rst_n low, asynchronous) empties both queues, clears position and
//   count, and loads the default register values.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection_top #(
    parameter int MAX_WIDTH  = dpb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dpb_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_STRIDE = dpb_pkg::MAX_STRIDE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  dpb_pkg::pixel_t                    pixel,
    output logic                               empty,
    input  logic                               pop,
    output dpb_pkg::point_t                    point,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dpb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dpb_pkg::CFG_DATA_W-1:0]     cfg_data
);

    dpb_pkg::cfg_t  cfg_reg;
    dpb_pkg::kept_t keep_item, mid_item;
    logic           accept, keep_push, mid_full, mid_empty, mid_pop;

    assign cfg_ready = 1'b1;

    // register bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= dpb_pkg::IMAGE_WIDTH_RST;
            cfg_reg.sample_step  <= dpb_pkg::SAMPLE_STEP_RST;
            cfg_reg.min_depth_mm <= dpb_pkg::MIN_DEPTH_RST;
            cfg_reg.max_depth_mm <= dpb_pkg::MAX_DEPTH_RST;
            cfg_reg.center_x_q4  <= dpb_pkg::CENTER_X_RST;
            cfg_reg.center_y_q4  <= dpb_pkg::CENTER_Y_RST;
            cfg_reg.inv_focal_x  <= dpb_pkg::INV_FOCAL_X_RST;
            cfg_reg.inv_focal_y  <= dpb_pkg::INV_FOCAL_Y_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dpb_pkg::REG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_data[12:0];
                dpb_pkg::REG_SAMPLE_STEP:  cfg_reg.sample_step  <= cfg_data[6:0];
                dpb_pkg::REG_MIN_DEPTH:    cfg_reg.min_depth_mm <= cfg_data[15:0];
                dpb_pkg::REG_MAX_DEPTH:    cfg_reg.max_depth_mm <= cfg_data[15:0];
                dpb_pkg::REG_CENTER_X:     cfg_reg.center_x_q4  <= cfg_data[15:0];
                dpb_pkg::REG_CENTER_Y:     cfg_reg.center_y_q4  <= cfg_data[15:0];
                dpb_pkg::REG_INV_FOCAL_X:  cfg_reg.inv_focal_x  <= cfg_data[23:0];
                dpb_pkg::REG_INV_FOCAL_Y:  cfg_reg.inv_focal_y  <= cfg_data[23:0];
                default:                   cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign full   = mid_full;
    assign accept = push && !mid_full;

    dpb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_STRIDE (MAX_STRIDE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .accept    (accept),
        .pixel     (pixel),
        .keep_push (keep_push),
        .keep_item (keep_item)
    );

    dpb_queue #(
        .WIDTH ($bits(dpb_pkg::kept_t)),
        .DEPTH (dpb_pkg::MID_DEPTH)
    ) u_mid_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (keep_push),
        .wr_data (keep_item),
        .full    (mid_full),
        .pop     (mid_pop),
        .rd_data (mid_item),
        .empty   (mid_empty)
    );

    dpb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item       (mid_item),
        .item_empty (mid_empty),
        .item_pop   (mid_pop),
        .pop        (pop),
        .empty      (empty),
        .point      (point)
    );

endmodule

[dv/dpb_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dpb_checker: point prediction and comparison for depth back-projection
// Watches the pixel, point and register channels, tracks raster position and
// register values, predicts each emitted point and checks it field by field.
// ----------------------------------------------------------------------------
module dpb_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  logic                            full,
    input  dpb_pkg::pixel_t                 pixel,
    input  logic                            empty,
    input  logic                            pop,
    input  dpb_pkg::point_t                 point,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [dpb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dpb_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              fail_count,
    output int                              pending
);

    dpb_pkg::cfg_t   regs;
    logic [11:0]     col;
    logic [11:0]     row;
    int              col_phase;
    int              row_phase;
    logic [23:0]     next_index;
    int              eff_width;
    int              eff_stride;
    dpb_pkg::point_t want;
    dpb_pkg::point_t points_due[$];
    int              errors = 0;

    // (16*pos - center) * z * inv / 2^24, rounded half away from zero, saturated
    function automatic logic [31:0] back_project(input logic [11:0] pos,
                                                 input logic [15:0] center,
                                                 input logic [15:0] z,
                                                 input logic [23:0] inv);
        logic [16:0] scaled;
        logic [16:0] offset;
        logic        neg;
        logic [63:0] mag;
        scaled = {1'b0, pos, 4'b0000};
        neg    = {1'b0, center} > scaled;
        offset = neg ? {1'b0, center} - scaled : scaled - {1'b0, center};
        mag    = offset;
        mag    = mag * z;
        mag    = mag * inv;
        mag    = (mag + 64'h80_0000) >> 24;
        if (neg)
        begin
            if (mag > 64'h8000_0000)
                mag = 64'h8000_0000;
            return -mag[31:0];
        end
        if (mag > 64'h7FFF_FFFF)
            mag = 64'h7FFF_FFFF;
        return mag[31:0];
    endfunction

    task automatic report(input string msg);
        errors++;
        if (errors <= 10)
            $display("%0t ERROR %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (act_val !== exp_val)
            report($sformatf("point %0d %s: expected 0x%h, got 0x%h",
                             want.point_index, name, exp_val, act_val));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.image_width  = dpb_pkg::IMAGE_WIDTH_RST;
            regs.sample_step  = dpb_pkg::SAMPLE_STEP_RST;
            regs.min_depth_mm = dpb_pkg::MIN_DEPTH_RST;
            regs.max_depth_mm = dpb_pkg::MAX_DEPTH_RST;
            regs.center_x_q4  = dpb_pkg::CENTER_X_RST;
            regs.center_y_q4  = dpb_pkg::CENTER_Y_RST;
            regs.inv_focal_x  = dpb_pkg::INV_FOCAL_X_RST;
            regs.inv_focal_y  = dpb_pkg::INV_FOCAL_Y_RST;
            col        = '0;
            row        = '0;
            col_phase  = 0;
            row_phase  = 0;
            next_index = '0;
            points_due.delete();
            pending    <= 0;
        end
        else
        begin
            // point transfer: compare with the oldest prediction
            if (pop && !empty)
            begin
                if (points_due.size() == 0)
                    report($sformatf("unexpected point x=0x%h y=0x%h z=%0d index=%0d",
                                     point.point_x, point.point_y, point.point_z,
                                     point.point_index));
                else
                begin
                    want = points_due.pop_front();
                    check_field("point_x", want.point_x, point.point_x);
                    check_field("point_y", want.point_y, point.point_y);
                    check_field("point_z", 32'(want.point_z), 32'(point.point_z));
                    check_field("point_index", 32'(want.point_index),
                                32'(point.point_index));
                end
            end

            // pixel transfer: grid and depth filter, then projection
            if (push && !full)
            begin
                eff_width  = (regs.image_width == 0) ? 1 :
                             (regs.image_width > dpb_pkg::MAX_WIDTH_DEF) ?
                             dpb_pkg::MAX_WIDTH_DEF : int'(regs.image_width);
                eff_stride = (regs.sample_step == 0) ? 1 :
                             (regs.sample_step > dpb_pkg::MAX_STRIDE_DEF) ?
                             dpb_pkg::MAX_STRIDE_DEF : int'(regs.sample_step);
                if (pixel.frame_start)
                begin
                    col        = '0;
                    row        = '0;
                    col_phase  = 0;
                    row_phase  = 0;
                    next_index = '0;
                end
                if (col_phase == 0 && row_phase == 0 && pixel.depth_mm != 0 &&
                    pixel.depth_mm >= regs.min_depth_mm &&
                    pixel.depth_mm <= regs.max_depth_mm)
                begin
                    want.point_x     = back_project(col, regs.center_x_q4,
                                                    pixel.depth_mm, regs.inv_focal_x);
                    want.point_y     = back_project(row, regs.center_y_q4,
                                                    pixel.depth_mm, regs.inv_focal_y);
                    want.point_z     = pixel.depth_mm;
                    want.point_index = next_index;
                    next_index       = next_index + 24'd1;
                    points_due.push_back(want);
                end
                // advance raster position
                if (int'(col) + 1 >= eff_width)
                begin
                    col       = '0;
                    col_phase = 0;
                    if (int'(row) + 1 >= dpb_pkg::MAX_HEIGHT_DEF)
                    begin
                        row       = '0;
                        row_phase = 0;
                    end
                    else
                    begin
                        row       = row + 12'd1;
                        row_phase = (row_phase + 1 >= eff_stride) ? 0 : row_phase + 1;
                    end
                end
                else
                begin
                    col       = col + 12'd1;
                    col_phase = (col_phase + 1 >= eff_stride) ? 0 : col_phase + 1;
                end
            end

            // register write
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    dpb_pkg::REG_IMAGE_WIDTH:  regs.image_width  = cfg_data[12:0];
                    dpb_pkg::REG_SAMPLE_STEP:  regs.sample_step  = cfg_data[6:0];
                    dpb_pkg::REG_MIN_DEPTH:    regs.min_depth_mm = cfg_data[15:0];
                    dpb_pkg::REG_MAX_DEPTH:    regs.max_depth_mm = cfg_data[15:0];
                    dpb_pkg::REG_CENTER_X:     regs.center_x_q4  = cfg_data[15:0];
                    dpb_pkg::REG_CENTER_Y:     regs.center_y_q4  = cfg_data[15:0];
                    dpb_pkg::REG_INV_FOCAL_X:  regs.inv_focal_x  = cfg_data[23:0];
                    dpb_pkg::REG_INV_FOCAL_Y:  regs.inv_focal_y  = cfg_data[23:0];
                    default: ;
                endcase
            end

            pending    <= points_due.size();
            fail_count <= errors;
        end
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for depth_pixel_backprojection_top
// Drives depth rasters and register settings with random gaps on both
// sides; the checker predicts every point and reports the failure count.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int STALL_LIMIT  = 5000;
    localparam int SETTLE       = 16;
    localparam int RANDOM_ITEMS = 600;
    localparam int COLUMN_ITEMS = 64;

    // raster under reset settings: stride grid at columns 0,4,8,.. and a restart at 17
    localparam logic [15:0] DIRECTED_DEPTH [24] = '{
        16'd1000, 16'd0, 16'd5, 16'd65535, 16'd0, 16'd1, 16'd2, 16'd3,
        16'd299, 16'd7, 16'd8, 16'd9, 16'd300, 16'd1, 16'd1, 16'd1,
        16'd40000, 16'd40000, 16'd1, 16'd1, 16'd1, 16'd40001, 16'd1, 16'd1
    };

    logic                            clk;
    logic                            rst_n;
    logic                            push;
    logic                            full;
    dpb_pkg::pixel_t                 pixel;
    logic                            empty;
    logic                            pop = 1'b0;
    dpb_pkg::point_t                 point;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [dpb_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [dpb_pkg::CFG_DATA_W-1:0]  cfg_data;
    int                              fail_count;
    int                              pending;
    logic                            steady = 1'b0;
    int                              stall_cycles = 0;
    dpb_pkg::cfg_t                   active;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    depth_pixel_backprojection_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pixel     (pixel),
        .empty     (empty),
        .pop       (pop),
        .point     (point),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dpb_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .pixel      (pixel),
        .empty      (empty),
        .pop        (pop),
        .point      (point),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // point consumer with random stalls
    always @(posedge clk)
    begin
        pop <= steady || ($urandom_range(0, 99) >= 24);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // one pixel transfer, with an occasional gap in front of it
    task automatic send_pixel(input logic [15:0] depth, input logic first);
        if (!steady && $urandom_range(0, 99) < 24)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        push  <= 1'b1;
        pixel <= {depth, first};
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // hold pixels until every predicted point has been transferred
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_one(input logic [dpb_pkg::CFG_INDEX_W-1:0] index,
                             input logic [dpb_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // write the whole register bank once the block is idle
    task automatic write_regs(input dpb_pkg::cfg_t c);
        drain();
        repeat (SETTLE) @(posedge clk);
        write_one(dpb_pkg::REG_IMAGE_WIDTH, dpb_pkg::CFG_DATA_W'(c.image_width));
        write_one(dpb_pkg::REG_SAMPLE_STEP, dpb_pkg::CFG_DATA_W'(c.sample_step));
        write_one(dpb_pkg::REG_MIN_DEPTH, dpb_pkg::CFG_DATA_W'(c.min_depth_mm));
        write_one(dpb_pkg::REG_MAX_DEPTH, dpb_pkg::CFG_DATA_W'(c.max_depth_mm));
        write_one(dpb_pkg::REG_CENTER_X, dpb_pkg::CFG_DATA_W'(c.center_x_q4));
        write_one(dpb_pkg::REG_CENTER_Y, dpb_pkg::CFG_DATA_W'(c.center_y_q4));
        write_one(dpb_pkg::REG_INV_FOCAL_X, c.inv_focal_x);
        write_one(dpb_pkg::REG_INV_FOCAL_Y, c.inv_focal_y);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [23:0] pick_inv();
        case ($urandom_range(0, 7))
            0:       return 24'd0;
            1:       return 24'hFF_FFFF;
            2:       return 24'($urandom());
            default: return 24'($urandom_range(1000, 200000));
        endcase
    endfunction

    function automatic logic [15:0] pick_center();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    // register settings biased toward small rows and strides plus extremes
    function automatic dpb_pkg::cfg_t random_cfg();
        dpb_pkg::cfg_t c;
        case ($urandom_range(0, 9))
            0:       c.image_width = 13'd0;
            1:       c.image_width = 13'd1;
            2:       c.image_width = 13'd4096;
            3:       c.image_width = 13'h1FFF;
            default: c.image_width = 13'($urandom_range(2, 24));
        endcase
        case ($urandom_range(0, 9))
            0:       c.sample_step = 7'd0;
            1:       c.sample_step = 7'd1;
            2:       c.sample_step = 7'd64;
            3:       c.sample_step = 7'h7F;
            default: c.sample_step = 7'($urandom_range(1, 4));
        endcase
        case ($urandom_range(0, 7))
            0:
            begin
                c.min_depth_mm = 16'd0;
                c.max_depth_mm = 16'hFFFF;
            end
            1:
            begin
                c.max_depth_mm = 16'($urandom_range(0, 30000));
                c.min_depth_mm = c.max_depth_mm + 16'($urandom_range(1, 30000));
            end
            2:
            begin
                c.min_depth_mm = 16'($urandom());
                c.max_depth_mm = c.min_depth_mm;
            end
            default:
            begin
                c.min_depth_mm = 16'($urandom_range(0, 2000));
                c.max_depth_mm = 16'($urandom_range(20000, 65535));
            end
        endcase
        c.center_x_q4 = pick_center();
        c.center_y_q4 = pick_center();
        c.inv_focal_x = pick_inv();
        c.inv_focal_y = pick_inv();
        return c;
    endfunction

    // depths at and around the window edges, zero, and random values
    function automatic logic [15:0] pick_depth(input dpb_pkg::cfg_t c);
        case ($urandom_range(0, 19))
            0:       return 16'd0;
            1:       return c.min_depth_mm;
            2:       return c.max_depth_mm;
            3:       return c.min_depth_mm - 16'd1;
            4:       return c.max_depth_mm + 16'd1;
            5:       return 16'hFFFF;
            6:       return 16'd1;
            7, 8, 9: return 16'($urandom());
            default:
            begin
                if (c.min_depth_mm <= c.max_depth_mm)
                    return 16'($urandom_range(c.min_depth_mm, c.max_depth_mm));
                return 16'($urandom());
            end
        endcase
    endfunction

    // stimulus
    initial
    begin
        int len;
        int random_items;
        int phase;
        rst_n     = 1'b0;
        push      = 1'b0;
        pixel     = '0;
        cfg_valid = 1'b0;
        cfg_index = dpb_pkg::REG_IMAGE_WIDTH;
        cfg_data  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed raster under reset settings
        for (int i = 0; i < 24; i++)
            send_pixel(DIRECTED_DEPTH[i], i == 0 || i == 17);

        // single-column raster with saturating projections
        active.image_width  = 13'd0;
        active.sample_step  = 7'd16;
        active.min_depth_mm = 16'd0;
        active.max_depth_mm = 16'hFFFF;
        active.center_x_q4  = 16'hFFFF;
        active.center_y_q4  = 16'd0;
        active.inv_focal_x  = 24'hFF_FFFF;
        active.inv_focal_y  = 24'hFF_FFFF;
        write_regs(active);
        steady <= 1'b1;
        for (int i = 0; i < COLUMN_ITEMS; i++)
            send_pixel(($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom()), i == 0);
        steady <= 1'b0;

        // random settings, each with a raster of random depths
        random_items = 0;
        phase        = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            active = random_cfg();
            write_regs(active);
            len = $urandom_range(40, 160);
            for (int k = 0; k < len; k++)
            begin
                send_pixel(pick_depth(active), k == 0 || $urandom_range(0, 99) < 2);
                random_items++;
                if (phase == 1 && k == len / 2)
                    drain();
            end
            phase++;
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
rtl/dpb_pkg.sv
rtl/dpb_queue.sv
rtl/dpb_front.sv
rtl/dpb_back.sv
rtl/depth_pixel_backprojection_top.sv
dv/dpb_checker.sv
dv/tb_top.sv
